FILE: hw/rtl/hrrn_ready_queue_dispatcher_top_assert.svh
// ---------------------------------------------------------------------------
// hrrn ready queue dispatcher assertion macros
// shared property forms for the controller and the datapath checks
// ---------------------------------------------------------------------------
`ifndef HRRN_READY_QUEUE_DISPATCHER_TOP_ASSERT_SVH
`define HRRN_READY_QUEUE_DISPATCHER_TOP_ASSERT_SVH

// same-cycle implication, switched off while reset is high
`define HRRN_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, switched off while reset is high
`define HRRN_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hw/rtl/hrrn_pkg.sv
// ---------------------------------------------------------------------------
// hrrn_pkg
// types, codes and widths shared by the ready queue dispatcher modules
// ---------------------------------------------------------------------------
package hrrn_pkg;

   localparam int unsigned READY_DEPTH_DEF = 16;

   localparam int unsigned ID_W       = 16;
   localparam int unsigned TIME_W     = 32;
   localparam int unsigned BURST_W    = 20;
   localparam int unsigned WEIGHT_W   = 9;
   localparam int unsigned FRAC_W     = 8;
   localparam int unsigned STATUS_W   = 2;
   localparam int unsigned COUNT_W    = 5;
   localparam int unsigned CSR_IDX_W  = 2;
   localparam int unsigned CSR_DATA_W = 20;
   localparam int unsigned PROD_W     = TIME_W + BURST_W;
   localparam int unsigned SUM_W      = BURST_W + WEIGHT_W + 1;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_MODE     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WEIGHT   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_INIT_EST = 2'd2;

   localparam logic                MODE_HRRN      = 1'b1;
   localparam logic [WEIGHT_W-1:0] WEIGHT_MAX     = 9'd256;
   localparam logic [WEIGHT_W-1:0] WEIGHT_RESET   = 9'd128;
   localparam logic [BURST_W-1:0]  INIT_EST_RESET = 20'd10000;

   localparam logic REQ_DISPATCH = 1'b1;

   // result status codes
   localparam logic [STATUS_W-1:0] ST_ENQUEUED   = 2'd0;
   localparam logic [STATUS_W-1:0] ST_DISPATCHED = 2'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY      = 2'd2;
   localparam logic [STATUS_W-1:0] ST_FULL       = 2'd3;

   typedef struct packed {
      logic               req_type;
      logic [ID_W-1:0]    process_id;
      logic [TIME_W-1:0]  ready_arrival_time;
      logic [BURST_W-1:0] previous_burst;
      logic [BURST_W-1:0] burst_estimate;
      logic [TIME_W-1:0]  current_time;
   } req_item_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [ID_W-1:0]     dispatched_id;
      logic [BURST_W-1:0]  dispatched_estimate;
      logic [COUNT_W-1:0]  ready_count;
   } rsp_item_type;

   typedef struct packed {
      logic [ID_W-1:0]    id;
      logic [TIME_W-1:0]  arrival;
      logic [BURST_W-1:0] prev_burst;
      logic [BURST_W-1:0] estimate;
   } entry_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DECIDE,
      S_PICK,
      S_LOAD,
      S_MUL_A,
      S_MUL_B,
      S_CMP,
      S_SHIFT,
      S_RESP
   } fsm_state_type;

   typedef struct packed {
      logic                latch_req;
      logic                set_status;
      logic [STATUS_W-1:0] status_code;
      logic                enq_write;
      logic                idx_clr;
      logic                idx_inc;
      logic                idx_best;
      logic                rd_ahead;
      logic                pick_head;
      logic                load_entry;
      logic                mul_a;
      logic                mul_b;
      logic                compare;
      logic                shift_write;
      logic                occ_dec;
   } ctrl_cmd_type;

   typedef struct packed {
      logic req_dispatch;
      logic mode_hrrn;
      logic empty;
      logic full;
      logic at_last;
   } dp_status_type;

endpackage

FILE: hw/rtl/hrrn_ctrl.sv
// ---------------------------------------------------------------------------
// hrrn_ctrl
// sequencer for enqueue, head pick, ratio scan and table compaction
// ---------------------------------------------------------------------------
`include "hrrn_ready_queue_dispatcher_top_assert.svh"

module hrrn_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   output logic                     rsp_valid,
   input  hrrn_pkg::dp_status_type  st,
   output hrrn_pkg::ctrl_cmd_type   cmd
);

   hrrn_pkg::fsm_state_type state_ff;
   hrrn_pkg::fsm_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= hrrn_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         hrrn_pkg::S_IDLE: begin
            if (start) state_in = hrrn_pkg::S_DECIDE;
         end
         hrrn_pkg::S_DECIDE: begin
            if (!st.req_dispatch || st.empty) begin
               state_in = hrrn_pkg::S_RESP;
            end else if (!st.mode_hrrn) begin
               state_in = hrrn_pkg::S_PICK;
            end else begin
               state_in = hrrn_pkg::S_LOAD;
            end
         end
         hrrn_pkg::S_PICK:  state_in = hrrn_pkg::S_SHIFT;
         hrrn_pkg::S_LOAD:  state_in = hrrn_pkg::S_MUL_A;
         hrrn_pkg::S_MUL_A: state_in = hrrn_pkg::S_MUL_B;
         hrrn_pkg::S_MUL_B: state_in = hrrn_pkg::S_CMP;
         hrrn_pkg::S_CMP: begin
            state_in = st.at_last ? hrrn_pkg::S_SHIFT : hrrn_pkg::S_LOAD;
         end
         hrrn_pkg::S_SHIFT: begin
            if (st.at_last) state_in = hrrn_pkg::S_RESP;
         end
         hrrn_pkg::S_RESP:  state_in = hrrn_pkg::S_IDLE;
         default:           state_in = hrrn_pkg::S_IDLE;
      endcase
   end

   // commands
   always_comb begin
      cmd = '0;
      case (state_ff)
         hrrn_pkg::S_IDLE: begin
            cmd.latch_req = start;
         end
         hrrn_pkg::S_DECIDE: begin
            cmd.set_status = 1'b1;
            if (!st.req_dispatch) begin
               cmd.status_code = st.full ? hrrn_pkg::ST_FULL : hrrn_pkg::ST_ENQUEUED;
               cmd.enq_write   = !st.full;
            end else if (st.empty) begin
               cmd.status_code = hrrn_pkg::ST_EMPTY;
            end else begin
               cmd.status_code = hrrn_pkg::ST_DISPATCHED;
               cmd.idx_clr     = 1'b1;
            end
         end
         hrrn_pkg::S_PICK: begin
            cmd.pick_head = 1'b1;
            cmd.idx_clr   = 1'b1;
            cmd.rd_ahead  = 1'b1;
         end
         hrrn_pkg::S_LOAD: begin
            cmd.load_entry = 1'b1;
         end
         hrrn_pkg::S_MUL_A: begin
            cmd.mul_a = 1'b1;
         end
         hrrn_pkg::S_MUL_B: begin
            cmd.mul_b = 1'b1;
         end
         hrrn_pkg::S_CMP: begin
            cmd.compare = 1'b1;
            if (st.at_last) begin
               cmd.idx_best = 1'b1;
               cmd.rd_ahead = 1'b1;
            end else begin
               cmd.idx_inc = 1'b1;
            end
         end
         hrrn_pkg::S_SHIFT: begin
            if (st.at_last) begin
               cmd.occ_dec = 1'b1;
            end else begin
               cmd.shift_write = 1'b1;
               cmd.idx_inc     = 1'b1;
               cmd.rd_ahead    = 1'b1;
            end
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   assign busy      = (state_ff != hrrn_pkg::S_IDLE);
   assign rsp_valid = (state_ff == hrrn_pkg::S_RESP);

   `HRRN_ASSERT_NEXT(a_accept_decides, clock, reset, start && !busy, state_ff == hrrn_pkg::S_DECIDE, "accepted item did not reach decide")
   `HRRN_ASSERT_NEXT(a_result_frees, clock, reset, rsp_valid, !busy && !rsp_valid, "block still busy after result")

endmodule

FILE: hw/rtl/hrrn_dpath.sv
// ---------------------------------------------------------------------------
// hrrn_dpath
// ready table memory, config registers, smoothing and ratio compare unit
// ---------------------------------------------------------------------------
`include "hrrn_ready_queue_dispatcher_top_assert.svh"

module hrrn_dpath #(
   parameter int unsigned READY_DEPTH = hrrn_pkg::READY_DEPTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  hrrn_pkg::ctrl_cmd_type              cmd,
   output hrrn_pkg::dp_status_type             st,
   input  hrrn_pkg::req_item_type              req_data,
   output hrrn_pkg::rsp_item_type              rsp_data,
   input  logic                                csr_we,
   input  logic [hrrn_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [hrrn_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int unsigned IDX_W = $clog2(READY_DEPTH);
   localparam int unsigned CNT_W = $clog2(READY_DEPTH + 1);
   localparam int unsigned BW    = hrrn_pkg::BURST_W;
   localparam int unsigned SW    = hrrn_pkg::SUM_W;

   // configuration
   logic                            mode_ff, mode_in;
   logic [hrrn_pkg::WEIGHT_W-1:0]   weight_ff, weight_in;
   logic [BW-1:0]                   init_est_ff, init_est_in;

   always_comb begin
      mode_in     = mode_ff;
      weight_in   = weight_ff;
      init_est_in = init_est_ff;
      if (csr_we) begin
         case (csr_index)
            hrrn_pkg::CSR_MODE:     mode_in     = csr_wdata[0];
            hrrn_pkg::CSR_WEIGHT:   weight_in   = csr_wdata[hrrn_pkg::WEIGHT_W-1:0];
            hrrn_pkg::CSR_INIT_EST: init_est_in = csr_wdata[BW-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= 1'b0;
         weight_ff   <= hrrn_pkg::WEIGHT_RESET;
         init_est_ff <= hrrn_pkg::INIT_EST_RESET;
      end else begin
         mode_ff     <= mode_in;
         weight_ff   <= weight_in;
         init_est_ff <= init_est_in;
      end
   end

   // request register
   hrrn_pkg::req_item_type req_ff;

   always_ff @(posedge clock) begin
      if (cmd.latch_req) req_ff <= req_data;
   end

   // occupancy and walk index
   logic [CNT_W-1:0] occ_ff, occ_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [IDX_W-1:0] best_pos_ff, best_pos_in;
   logic [IDX_W-1:0] rd_addr;

   always_comb begin
      occ_in = occ_ff;
      if (cmd.enq_write) begin
         occ_in = occ_ff + CNT_W'(1);
      end else if (cmd.occ_dec) begin
         occ_in = occ_ff - CNT_W'(1);
      end
   end

   always_comb begin
      if (cmd.idx_clr) begin
         idx_in = '0;
      end else if (cmd.idx_inc) begin
         idx_in = idx_ff + IDX_W'(1);
      end else if (cmd.idx_best) begin
         idx_in = best_pos_in;
      end else begin
         idx_in = idx_ff;
      end
   end

   // compaction reads one place ahead of the place being written
   assign rd_addr = cmd.rd_ahead ? (idx_in + IDX_W'(1)) : idx_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= '0;
         idx_ff <= '0;
      end else begin
         occ_ff <= occ_in;
         idx_ff <= idx_in;
      end
   end

   // ready table
   hrrn_pkg::entry_type mem_ff [READY_DEPTH];
   hrrn_pkg::entry_type rd_ff;
   hrrn_pkg::entry_type mem_wdata;
   logic [IDX_W-1:0]    mem_waddr;
   logic                mem_we;

   // estimate fix-up and smoothing
   logic                      need_fix;
   logic [BW-1:0]             fix_est;
   logic [BW-1:0]             fix_prev;
   logic [hrrn_pkg::WEIGHT_W-1:0] weight_sat;
   logic signed [BW:0]        diff;
   logic signed [SW-1:0]      wprod;
   logic signed [SW-1:0]      sum;
   logic [BW-1:0]             smooth_est;
   logic [hrrn_pkg::TIME_W-1:0] wait_now;

   assign need_fix   = (rd_ff.estimate == '0);
   assign fix_est    = need_fix ? init_est_ff : rd_ff.estimate;
   assign fix_prev   = need_fix ? '0 : rd_ff.prev_burst;
   assign weight_sat = (weight_ff > hrrn_pkg::WEIGHT_MAX) ? hrrn_pkg::WEIGHT_MAX : weight_ff;
   assign diff       = $signed({1'b0, fix_prev}) - $signed({1'b0, fix_est});

   // a*prev + (256-a)*est folded into est*256 + a*(prev-est)
   assign wprod = $signed({{(SW - hrrn_pkg::WEIGHT_W){1'b0}}, weight_sat})
                * $signed({{(SW - BW - 1){diff[BW]}}, diff});
   assign sum   = $signed({{(SW - BW - hrrn_pkg::FRAC_W){1'b0}}, fix_est,
                           {hrrn_pkg::FRAC_W{1'b0}}}) + wprod;
   assign smooth_est = sum[hrrn_pkg::FRAC_W+BW-1:hrrn_pkg::FRAC_W];

   // negative wait clamps to zero
   assign wait_now = (req_ff.current_time >= rd_ff.arrival) ?
                     (req_ff.current_time - rd_ff.arrival) : '0;

   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = idx_ff;
      mem_wdata = rd_ff;
      if (cmd.enq_write) begin
         mem_we    = 1'b1;
         mem_waddr = occ_ff[IDX_W-1:0];
         mem_wdata.id         = req_ff.process_id;
         mem_wdata.arrival    = req_ff.ready_arrival_time;
         mem_wdata.prev_burst = req_ff.previous_burst;
         mem_wdata.estimate   = req_ff.burst_estimate;
      end else if (cmd.load_entry) begin
         // missing estimate is written back as the initial one
         mem_we               = need_fix;
         mem_wdata.prev_burst = '0;
         mem_wdata.estimate   = init_est_ff;
      end else if (cmd.shift_write) begin
         mem_we = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) mem_ff[mem_waddr] <= mem_wdata;
      rd_ff <= mem_ff[rd_addr];
   end

   // candidate, products and best so far
   logic [BW-1:0]                 e_ff;
   logic [hrrn_pkg::TIME_W-1:0]   wait_ff;
   logic [hrrn_pkg::ID_W-1:0]     cand_id_ff;
   logic [hrrn_pkg::PROD_W-1:0]   prod_new_ff;
   logic [hrrn_pkg::PROD_W-1:0]   prod_best_ff;
   logic [hrrn_pkg::PROD_W-1:0]   mul_out;
   logic [hrrn_pkg::TIME_W-1:0]   mul_x;
   logic [BW-1:0]                 mul_y;
   logic [BW-1:0]                 best_est_ff;
   logic [hrrn_pkg::TIME_W-1:0]   best_wait_ff;
   logic [hrrn_pkg::ID_W-1:0]     best_id_ff;
   logic [hrrn_pkg::STATUS_W-1:0] status_ff;
   logic                          better;

   // one shared multiplier: wait*best_est, then best_wait*e
   assign mul_x   = cmd.mul_b ? best_wait_ff : wait_ff;
   assign mul_y   = cmd.mul_b ? e_ff : best_est_ff;
   assign mul_out = {{BW{1'b0}}, mul_x} * {{hrrn_pkg::TIME_W{1'b0}}, mul_y};

   // zero estimate is an infinite ratio, ties keep the earlier entry
   always_comb begin
      if (idx_ff == '0) begin
         better = 1'b1;
      end else if (e_ff == '0) begin
         better = (best_est_ff != '0);
      end else if (best_est_ff == '0) begin
         better = 1'b0;
      end else begin
         better = (prod_new_ff > prod_best_ff);
      end
   end

   always_comb begin
      if (cmd.pick_head) begin
         best_pos_in = '0;
      end else if (cmd.compare && better) begin
         best_pos_in = idx_ff;
      end else begin
         best_pos_in = best_pos_ff;
      end
   end

   always_ff @(posedge clock) begin
      best_pos_ff <= best_pos_in;
      if (cmd.load_entry) begin
         e_ff       <= smooth_est;
         wait_ff    <= wait_now;
         cand_id_ff <= rd_ff.id;
      end
      if (cmd.mul_a) prod_new_ff  <= mul_out;
      if (cmd.mul_b) prod_best_ff <= mul_out;
      if (cmd.pick_head) begin
         best_id_ff  <= rd_ff.id;
         best_est_ff <= rd_ff.estimate;
      end else if (cmd.compare && better) begin
         best_id_ff   <= cand_id_ff;
         best_est_ff  <= e_ff;
         best_wait_ff <= wait_ff;
      end
      if (cmd.set_status) status_ff <= cmd.status_code;
   end

   // status to the controller
   assign st.req_dispatch = (req_ff.req_type == hrrn_pkg::REQ_DISPATCH);
   assign st.mode_hrrn    = (mode_ff == hrrn_pkg::MODE_HRRN);
   assign st.empty        = (occ_ff == '0);
   assign st.full         = (occ_ff == CNT_W'(READY_DEPTH));
   assign st.at_last      = ((CNT_W'(idx_ff) + CNT_W'(1)) == occ_ff);

   // result item
   always_comb begin
      rsp_data.status              = status_ff;
      rsp_data.dispatched_id       = '0;
      rsp_data.dispatched_estimate = '0;
      rsp_data.ready_count         = hrrn_pkg::COUNT_W'(occ_ff);
      if (status_ff == hrrn_pkg::ST_DISPATCHED) begin
         rsp_data.dispatched_id       = best_id_ff;
         rsp_data.dispatched_estimate = best_est_ff;
      end
   end

   `HRRN_ASSERT_NOW(a_occ_bound, clock, reset, 1'b1, occ_ff <= CNT_W'(READY_DEPTH), "occupancy above table depth")
   `HRRN_ASSERT_NOW(a_no_enq_full, clock, reset, cmd.enq_write, !st.full, "enqueue write into full table")
   `HRRN_ASSERT_NOW(a_no_dec_empty, clock, reset, cmd.occ_dec, !st.empty, "removal from empty table")

endmodule

FILE: hw/rtl/hrrn_ready_queue_dispatcher_top.sv
// ---------------------------------------------------------------------------
// hrrn_ready_queue_dispatcher_top
// Ordered ready table of up to READY_DEPTH processes with FIFO or highest
// response ratio next dispatch. A request is taken when start is high and
// busy is low; exactly one result follows, shown for a single cycle with
// rsp_valid high, and it cannot be held off, so the receiver must take it
// then. Enqueue, full-table and empty-table requests go from the decide
// state straight to the result. A FIFO dispatch takes the head entry, then
// compacts the table through its single write port. In an HRRN dispatch
// every entry is read, smoothed, cross-multiplied through one shared 32x20
// multiplier and compared, then the entries behind the chosen one move up
// one place a cycle. Configuration is written through csr_we, csr_index
// and csr_wdata; the user must do so only while the block is not busy, as
// the block itself does not enforce it.
// ---------------------------------------------------------------------------
module hrrn_ready_queue_dispatcher_top #(
   parameter int unsigned READY_DEPTH = hrrn_pkg::READY_DEPTH_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  hrrn_pkg::req_item_type           req_data,
   output logic                             rsp_valid,
   output hrrn_pkg::rsp_item_type           rsp_data,
   input  logic                             csr_we,
   input  logic [hrrn_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [hrrn_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   hrrn_pkg::ctrl_cmd_type  cmd;
   hrrn_pkg::dp_status_type st;

   hrrn_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .st        (st),
      .cmd       (cmd)
   );

   hrrn_dpath #(
      .READY_DEPTH (READY_DEPTH)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .st        (st),
      .req_data  (req_data),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

endmodule
